/* hw/rtl/sots_pkg.sv */
`default_nettype none

package sots_pkg;

  localparam int HOLD_W     = 16;
  localparam int NOW_W      = 32;
  localparam int CNT_W      = 32;
  localparam int DELTA_W    = 8;
  localparam int MASK_W     = 8;
  localparam int OUTLET_W   = 3;
  localparam int CFG_IDX_W  = 3;

  localparam int OUTLET_COUNT_DEF = 8;

  // display redraw on every eighth open action in endurance mode
  localparam int REFRESH_LSBS = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_OPEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_CLOSED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_OPEN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_CLOSED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDURANCE_OPEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENDURANCE_CLOSED = 3'd5;

  localparam logic [HOLD_W-1:0] RST_ROTATE_OPEN      = 16'd1000;
  localparam logic [HOLD_W-1:0] RST_ROTATE_CLOSED    = 16'd500;
  localparam logic [HOLD_W-1:0] RST_SINGLE_OPEN      = 16'd300;
  localparam logic [HOLD_W-1:0] RST_SINGLE_CLOSED    = 16'd500;
  localparam logic [HOLD_W-1:0] RST_ENDURANCE_OPEN   = 16'd300;
  localparam logic [HOLD_W-1:0] RST_ENDURANCE_CLOSED = 16'd100;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_ROTATE    = 2'd0,
    MODE_SINGLE    = 2'd1,
    MODE_ENDURANCE = 2'd2,
    MODE_HALT      = 2'd3
  } mode_e;

  typedef struct packed {
    logic [HOLD_W-1:0] rotate_open;
    logic [HOLD_W-1:0] rotate_closed;
    logic [HOLD_W-1:0] single_open;
    logic [HOLD_W-1:0] single_closed;
    logic [HOLD_W-1:0] endurance_open;
    logic [HOLD_W-1:0] endurance_closed;
  } hold_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]   drive_mask;
    logic [OUTLET_W-1:0] current_outlet;
    logic                pulse_open;
    logic [CNT_W-1:0]    cycles_done;
    logic                refresh_display;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sots_cfg.sv */
`default_nettype none

module sots_cfg
  import sots_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [HOLD_W-1:0]    cfg_wdata_i,
  output hold_cfg_t                 hold_o
);

  hold_cfg_t hold_q, hold_d;

  always_comb begin
    hold_d = hold_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROTATE_OPEN:      hold_d.rotate_open      = cfg_wdata_i;
        CFG_ROTATE_CLOSED:    hold_d.rotate_closed    = cfg_wdata_i;
        CFG_SINGLE_OPEN:      hold_d.single_open      = cfg_wdata_i;
        CFG_SINGLE_CLOSED:    hold_d.single_closed    = cfg_wdata_i;
        CFG_ENDURANCE_OPEN:   hold_d.endurance_open   = cfg_wdata_i;
        CFG_ENDURANCE_CLOSED: hold_d.endurance_closed = cfg_wdata_i;
        default:              hold_d = hold_q;   // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q.rotate_open      <= RST_ROTATE_OPEN;
      hold_q.rotate_closed    <= RST_ROTATE_CLOSED;
      hold_q.single_open      <= RST_SINGLE_OPEN;
      hold_q.single_closed    <= RST_SINGLE_CLOSED;
      hold_q.endurance_open   <= RST_ENDURANCE_OPEN;
      hold_q.endurance_closed <= RST_ENDURANCE_CLOSED;
    end else begin
      hold_q <= hold_d;
    end
  end

  assign hold_o = hold_q;

endmodule

`default_nettype wire

/* hw/rtl/sots_step.sv */
`default_nettype none

module sots_step
  import sots_pkg::*;
#(
  parameter int OUTLET_COUNT = OUTLET_COUNT_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  cmd_e                    cmd_i,
  input  wire logic [NOW_W-1:0]   now_i,
  input  wire logic [1:0]         mode_i,
  input  wire logic [DELTA_W-1:0] delta_i,
  input  hold_cfg_t               hold_i,
  output result_t                 res_o
);

  localparam int IDX_W   = $clog2(OUTLET_COUNT);
  localparam int DELTA_N = 2 ** DELTA_W;

  mode_e                   mode_q, mode_d;
  logic                    init_q, init_d;
  logic [NOW_W-1:0]        last_q, last_d;
  logic                    open_q, open_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [OUTLET_COUNT-1:0] drv_q, drv_d;

  logic                    refresh;
  logic [HOLD_W-1:0]       hold;
  logic [NOW_W-1:0]        elapsed;
  logic                    due;
  logic [IDX_W:0]          step_sum;
  logic [IDX_W-1:0]        delta_mod [DELTA_N];

  // encoder step reduced modulo the outlet count, one entry per raw code
  for (genvar g = 0; g < DELTA_N; g++) begin : g_dmod
    localparam int SV = (g >= DELTA_N / 2) ? g - DELTA_N : g;
    localparam int RM = ((SV % OUTLET_COUNT) + OUTLET_COUNT) % OUTLET_COUNT;
    assign delta_mod[g] = IDX_W'(RM);
  end

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(OUTLET_COUNT - 1)) r = '0;
    else                               r = i + IDX_W'(1);
    return r;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    init_d   = init_q;
    last_d   = last_q;
    open_d   = open_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    drv_d    = drv_q;
    refresh  = 1'b0;
    hold     = '0;
    elapsed  = '0;
    due      = 1'b0;
    step_sum = {1'b0, idx_q} + {1'b0, delta_mod[delta_i]};

    case (cmd_i)
      CMD_TICK: begin
        if (init_q) begin
          init_d = 1'b0;
          last_d = now_i;
          open_d = 1'b0;
          idx_d  = '0;
          cnt_d  = '0;
          if (mode_q != MODE_ENDURANCE) begin
            drv_d[0] = 1'b0;
            refresh  = 1'b1;
          end
        end

        case (mode_q)
          MODE_ROTATE:    hold = open_d ? hold_i.rotate_open    : hold_i.rotate_closed;
          MODE_SINGLE:    hold = open_d ? hold_i.single_open    : hold_i.single_closed;
          MODE_ENDURANCE: hold = open_d ? hold_i.endurance_open : hold_i.endurance_closed;
          default:        hold = '0;
        endcase

        // wrapping difference, so a rollover of the ms clock is harmless
        elapsed = now_i - last_d;
        due     = (mode_q != MODE_HALT) && (elapsed >= {{(NOW_W-HOLD_W){1'b0}}, hold});

        if (due) begin
          last_d = now_i;
          open_d = ~open_d;
          case (mode_q)
            MODE_ROTATE: begin
              if (open_d) idx_d = next_idx(idx_d);
              drv_d[idx_d] = open_d;
              refresh      = 1'b1;
            end
            MODE_SINGLE: begin
              drv_d   = open_d ? (OUTLET_COUNT'(1) << idx_d) : '0;
              refresh = 1'b1;
            end
            MODE_ENDURANCE: begin
              if (open_d) begin
                cnt_d   = cnt_d + CNT_W'(1);
                refresh = (cnt_d[REFRESH_LSBS-1:0] == '0);
              end else begin
                idx_d = next_idx(idx_d);
              end
              drv_d = open_d ? (OUTLET_COUNT'(1) << idx_d) : '0;
            end
            default: drv_d = drv_q;
          endcase
        end
      end

      CMD_START: begin
        mode_d = mode_e'(mode_i);
        init_d = 1'b1;
        cnt_d  = '0;
        open_d = 1'b0;
      end

      CMD_STEP: begin
        if (mode_q == MODE_SINGLE && delta_i != '0) begin
          if (step_sum >= (IDX_W+1)'(OUTLET_COUNT))
            idx_d = IDX_W'(step_sum - (IDX_W+1)'(OUTLET_COUNT));
          else
            idx_d = IDX_W'(step_sum);
          open_d  = 1'b0;
          last_d  = now_i;
          drv_d   = '0;
          refresh = 1'b1;
        end
      end

      CMD_STOP: drv_d = '0;

      default: drv_d = drv_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ROTATE;
      init_q <= 1'b1;
      last_q <= '0;
      open_q <= 1'b0;
      idx_q  <= '0;
      cnt_q  <= '0;
      drv_q  <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      init_q <= init_d;
      last_q <= last_d;
      open_q <= open_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      drv_q  <= drv_d;
    end
  end

  // wide rows show only the low outlets and the low index bits
  assign res_o.drive_mask      = MASK_W'(drv_d);
  assign res_o.current_outlet  = OUTLET_W'(idx_d);
  assign res_o.pulse_open      = open_d;
  assign res_o.cycles_done     = cnt_d;
  assign res_o.refresh_display = refresh;

endmodule

`default_nettype wire

/* hw/rtl/solenoid_outlet_test_sequencer.sv */
// Channel  | Handshake                 | Payload
// ---------+---------------------------+---------------------------------------------
// in       | in_valid_i / in_ready_o   | command_i, now_ms_i, test_mode_i, step_delta_i
// out      | out_valid_o / out_ready_i | drive_mask_o, current_outlet_o, pulse_open_o,
//          |                           | cycles_done_o, refresh_display_o
// cfg      | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One beat in, one beat out; a beat is taken every cycle when the output is drained.
// The path runs through the input register, then the step logic into the result register.
// A stalled result holds; the input register still takes one more beat meanwhile.
// Reset restores default hold times, closes all outlets and arms initialisation.
`default_nettype none

module solenoid_outlet_test_sequencer
  import sots_pkg::*;
#(
  parameter int OUTLET_COUNT = OUTLET_COUNT_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [HOLD_W-1:0]    cfg_wdata_i,

  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           command_i,
  input  wire logic [NOW_W-1:0]     now_ms_i,
  input  wire logic [1:0]           test_mode_i,
  input  wire logic signed [DELTA_W-1:0] step_delta_i,

  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [MASK_W-1:0]         drive_mask_o,
  output logic [OUTLET_W-1:0]       current_outlet_o,
  output logic                      pulse_open_o,
  output logic [CNT_W-1:0]          cycles_done_o,
  output logic                      refresh_display_o
);

  hold_cfg_t            hold;
  result_t              res, res_q;

  logic                 in_vld_q;
  cmd_e                 cmd_q;
  logic [NOW_W-1:0]     now_q;
  logic [1:0]           mode_q;
  logic [DELTA_W-1:0]   delta_q;
  logic                 out_vld_q;
  logic                 advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  sots_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hold_o      (hold)
  );

  sots_step #(
    .OUTLET_COUNT (OUTLET_COUNT)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .cmd_i   (cmd_q),
    .now_i   (now_q),
    .mode_i  (mode_q),
    .delta_i (delta_q),
    .hold_i  (hold),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance)          out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_e'(command_i);
      now_q   <= now_ms_i;
      mode_q  <= test_mode_i;
      delta_q <= step_delta_i;
    end
    if (advance) res_q <= res;
  end

  assign out_valid_o       = out_vld_q;
  assign drive_mask_o      = res_q.drive_mask;
  assign current_outlet_o  = res_q.current_outlet;
  assign pulse_open_o      = res_q.pulse_open;
  assign cycles_done_o     = res_q.cycles_done;
  assign refresh_display_o = res_q.refresh_display;

`ifndef SYNTHESIS
  a_adv_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("processed beat did not reach the result register");

  a_held_in_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("pending input beat lost");

  a_start_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q == CMD_START) |-> !res.refresh_display)
    else $error("start command raised display refresh");

  a_stop_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && cmd_q == CMD_STOP) |-> (res.drive_mask == '0))
    else $error("stop command left an outlet driven");
`endif

endmodule

`default_nettype wire

/* tb/tb_solenoid_outlet_test_sequencer.sv */
`timescale 1ns / 1ps

module tb_solenoid_outlet_test_sequencer;
  import sots_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_REG_COUNT = 6;
  localparam int CHUNK_BEATS    = 290;
  localparam int CHUNK_COUNT    = 6;

  localparam logic [CFG_IDX_W-1:0] HOLD_REGS [HOLD_REG_COUNT] = '{
    CFG_ROTATE_OPEN, CFG_ROTATE_CLOSED, CFG_SINGLE_OPEN,
    CFG_SINGLE_CLOSED, CFG_ENDURANCE_OPEN, CFG_ENDURANCE_CLOSED
  };

  typedef struct packed {
    cmd_e                      cmd;
    logic [NOW_W-1:0]          now;
    mode_e                     mode;
    logic signed [DELTA_W-1:0] delta;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx = CFG_ROTATE_OPEN;
  logic [HOLD_W-1:0]         cfg_wdata = '0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  cmd_e                      in_command = CMD_TICK;
  logic [NOW_W-1:0]          in_now_ms = '0;
  mode_e                     in_test_mode = MODE_ROTATE;
  logic signed [DELTA_W-1:0] in_step_delta = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [MASK_W-1:0]         drive_mask;
  logic [OUTLET_W-1:0]       current_outlet;
  logic                      pulse_open;
  logic [CNT_W-1:0]          cycles_done;
  logic                      refresh_display;

  // stimulus and scoreboard
  beat_t       pending_beats[$];
  result_t     expected_results[$];
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 54;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic [NOW_W-1:0] sim_ms = '0;

  // predictor state
  logic [HOLD_W-1:0]   hold_ms [HOLD_REG_COUNT];
  mode_e               seq_mode;
  logic                seq_init_armed;
  logic [NOW_W-1:0]    seq_last_ms;
  logic                seq_open;
  logic [OUTLET_W-1:0] seq_outlet;
  logic [CNT_W-1:0]    seq_cycles;
  logic [MASK_W-1:0]   seq_drive;

  solenoid_outlet_test_sequencer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .command_i         (in_command),
    .now_ms_i          (in_now_ms),
    .test_mode_i       (in_test_mode),
    .step_delta_i      (in_step_delta),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .drive_mask_o      (drive_mask),
    .current_outlet_o  (current_outlet),
    .pulse_open_o      (pulse_open),
    .cycles_done_o     (cycles_done),
    .refresh_display_o (refresh_display)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [MASK_W-1:0] outlet_bit(input logic [OUTLET_W-1:0] idx);
    return MASK_W'(1) << idx;
  endfunction

  function automatic logic [OUTLET_W-1:0] following_outlet(input logic [OUTLET_W-1:0] idx);
    return OUTLET_W'((int'(idx) + 1) % OUTLET_COUNT_DEF);
  endfunction

  // wrapping elapsed time against the hold of the current phase; when due, restarts the timer and flips the phase
  function automatic logic hold_elapsed(input logic [NOW_W-1:0] now,
                                        input logic [HOLD_W-1:0] open_ms,
                                        input logic [HOLD_W-1:0] closed_ms);
    logic [NOW_W-1:0] elapsed;
    logic [NOW_W-1:0] hold;
    elapsed = now - seq_last_ms;
    hold = seq_open ? NOW_W'(open_ms) : NOW_W'(closed_ms);
    if (elapsed < hold) return 1'b0;
    seq_last_ms = now;
    seq_open = !seq_open;
    return 1'b1;
  endfunction

  function automatic result_t advance_sequencer(input beat_t b);
    result_t r;
    logic    redraw;
    int      moved;
    redraw = 1'b0;
    case (b.cmd)
      CMD_TICK: begin
        if (seq_init_armed) begin
          seq_init_armed = 1'b0;
          seq_last_ms = b.now;
          seq_open = 1'b0;
          seq_outlet = '0;
          seq_cycles = '0;
          if (seq_mode != MODE_ENDURANCE) begin
            seq_drive = seq_drive & ~outlet_bit('0);
            redraw = 1'b1;
          end
        end
        case (seq_mode)
          MODE_ROTATE: begin
            if (hold_elapsed(b.now, hold_ms[CFG_ROTATE_OPEN], hold_ms[CFG_ROTATE_CLOSED])) begin
              if (seq_open) begin
                seq_outlet = following_outlet(seq_outlet);
                seq_drive = seq_drive | outlet_bit(seq_outlet);
              end else begin
                seq_drive = seq_drive & ~outlet_bit(seq_outlet);
              end
              redraw = 1'b1;
            end
          end
          MODE_SINGLE: begin
            if (hold_elapsed(b.now, hold_ms[CFG_SINGLE_OPEN], hold_ms[CFG_SINGLE_CLOSED])) begin
              seq_drive = seq_open ? outlet_bit(seq_outlet) : '0;
              redraw = 1'b1;
            end
          end
          MODE_ENDURANCE: begin
            if (hold_elapsed(b.now, hold_ms[CFG_ENDURANCE_OPEN],
                             hold_ms[CFG_ENDURANCE_CLOSED])) begin
              if (seq_open) begin
                seq_cycles = seq_cycles + 1;
                if (seq_cycles[REFRESH_LSBS-1:0] == '0) redraw = 1'b1;
              end else begin
                seq_outlet = following_outlet(seq_outlet);
              end
              seq_drive = seq_open ? outlet_bit(seq_outlet) : '0;
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        seq_mode = b.mode;
        seq_init_armed = 1'b1;
        seq_cycles = '0;
        seq_open = 1'b0;
      end
      CMD_STEP: begin
        if (seq_mode == MODE_SINGLE && b.delta != 0) begin
          moved = (int'(seq_outlet) + int'(b.delta)) % OUTLET_COUNT_DEF;
          if (moved < 0) moved = moved + OUTLET_COUNT_DEF;
          seq_outlet = OUTLET_W'(moved);
          seq_open = 1'b0;
          seq_last_ms = b.now;
          seq_drive = '0;
          redraw = 1'b1;
        end
      end
      default: seq_drive = '0;
    endcase
    r.drive_mask = seq_drive;
    r.current_outlet = seq_outlet;
    r.pulse_open = seq_open;
    r.cycles_done = seq_cycles;
    r.refresh_display = redraw;
    return r;
  endfunction

  function automatic void queue_beat(input cmd_e cmd, input logic [NOW_W-1:0] now,
                                     input mode_e mode, input logic [DELTA_W-1:0] delta);
    beat_t b;
    b.cmd = cmd;
    b.now = now;
    b.mode = mode;
    b.delta = delta;
    pending_beats.push_back(b);
  endfunction

  function automatic void advance_clock(input int unsigned span);
    if ($urandom_range(31) == 0) sim_ms = $urandom;
    else sim_ms = sim_ms + $urandom_range(span);
  endfunction

  // a start, then mostly ticks on a rising time base, with steps, stops and noise
  function automatic int unsigned queue_session(input int unsigned span);
    mode_e       m;
    int unsigned len;
    int unsigned pick;
    int unsigned step_pct;
    pick = $urandom_range(15);
    m = (pick < 5) ? MODE_ROTATE : (pick < 10) ? MODE_SINGLE :
        (pick < 15) ? MODE_ENDURANCE : MODE_HALT;
    step_pct = (m == MODE_SINGLE) ? 30 : 16;
    len = $urandom_range(8, 60);
    queue_beat(CMD_START, $urandom, m, $urandom);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        queue_beat(cmd_e'($urandom_range(3)), $urandom, mode_e'($urandom_range(3)), $urandom);
      end else if (pick < 12) begin
        queue_beat(CMD_STOP, $urandom, mode_e'($urandom_range(3)), $urandom);
      end else if (pick < step_pct) begin
        sim_ms = sim_ms + $urandom_range(span / 4 + 1);
        queue_beat(CMD_STEP, sim_ms, mode_e'($urandom_range(3)), $urandom);
      end else begin
        advance_clock(span);
        queue_beat(CMD_TICK, sim_ms, mode_e'($urandom_range(3)), $urandom);
      end
    end
    return len + 1;
  endfunction

  task automatic wait_drained();
    while (pending_beats.size() != 0 || expected_results.size() != 0 || in_valid)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_hold(input logic [CFG_IDX_W-1:0] idx, input logic [HOLD_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    hold_ms[idx] = value;
  endtask

  task automatic apply_setting(input int setting);
    logic [HOLD_W-1:0] value;
    for (int r = 0; r < HOLD_REG_COUNT; r++) begin
      case (setting)
        2: value = '0;
        3: value = '1;
        4: begin
          case ($urandom_range(3))
            0: value = '0;
            1: value = 16'd1;
            2: value = $urandom_range(1, 60);
            default: value = '1;
          endcase
        end
        default: value = $urandom_range(1, 40);
      endcase
      write_hold(HOLD_REGS[r], value);
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int unsigned clock_span();
    int unsigned widest;
    widest = 0;
    for (int r = 0; r < HOLD_REG_COUNT; r++)
      if (hold_ms[HOLD_REGS[r]] > widest) widest = hold_ms[HOLD_REGS[r]];
    return widest / 2 + 2;
  endfunction

  // driver: next beat goes out once the current one is taken
  always @(posedge clk_i) begin : drive_beats
    beat_t b;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        b.cmd = in_command;
        b.now = in_now_ms;
        b.mode = in_test_mode;
        b.delta = in_step_delta;
        expected_results.push_back(advance_sequencer(b));
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          b = pending_beats.pop_front();
          in_command <= b.cmd;
          in_now_ms <= b.now;
          in_test_mode <= b.mode;
          in_step_delta <= b.delta;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        seen.drive_mask = drive_mask;
        seen.current_outlet = current_outlet;
        seen.pulse_open = pulse_open;
        seen.cycles_done = cycles_done;
        seen.refresh_display = refresh_display;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: mask %h outlet %0d open %b cycles %0d refresh %b",
                     seen.drive_mask, seen.current_outlet, seen.pulse_open,
                     seen.cycles_done, seen.refresh_display);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (seen.drive_mask !== want.drive_mask ||
              seen.current_outlet !== want.current_outlet ||
              seen.pulse_open !== want.pulse_open ||
              seen.cycles_done !== want.cycles_done ||
              seen.refresh_display !== want.refresh_display) begin
            // fields in order: mask, outlet, open, cycles, refresh
            if (mismatch_count < 10)
              $display("mismatch at %0t: exp %h/%0d/%b/%0d/%b got %h/%0d/%b/%0d/%b",
                       $realtime,
                       want.drive_mask, want.current_outlet, want.pulse_open,
                       want.cycles_done, want.refresh_display,
                       seen.drive_mask, seen.current_outlet, seen.pulse_open,
                       seen.cycles_done, seen.refresh_display);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned queued;
    hold_ms[CFG_ROTATE_OPEN] = RST_ROTATE_OPEN;
    hold_ms[CFG_ROTATE_CLOSED] = RST_ROTATE_CLOSED;
    hold_ms[CFG_SINGLE_OPEN] = RST_SINGLE_OPEN;
    hold_ms[CFG_SINGLE_CLOSED] = RST_SINGLE_CLOSED;
    hold_ms[CFG_ENDURANCE_OPEN] = RST_ENDURANCE_OPEN;
    hold_ms[CFG_ENDURANCE_CLOSED] = RST_ENDURANCE_CLOSED;
    seq_mode = MODE_ROTATE;
    seq_init_armed = 1'b1;
    seq_last_ms = '0;
    seq_open = 1'b0;
    seq_outlet = '0;
    seq_cycles = '0;
    seq_drive = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // rotate from reset: init, just short of the closed hold, then due
    queue_beat(CMD_TICK, 32'd100, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'd599, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'd600, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_STEP, 32'd700, MODE_ROTATE, 8'sd5);
    queue_beat(CMD_STOP, 32'hFFFF_FFFF, MODE_HALT, -8'sd1);
    queue_beat(CMD_TICK, 32'd1600, MODE_ROTATE, 8'sd0);
    // single outlet, steps at both ends of the delta range and zero
    queue_beat(CMD_START, 32'd1700, MODE_SINGLE, 8'sd0);
    queue_beat(CMD_TICK, 32'd2000, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_STEP, 32'd2100, MODE_ROTATE, 8'sd127);
    queue_beat(CMD_STEP, 32'd2200, MODE_ROTATE, -8'sd128);
    queue_beat(CMD_STEP, 32'd2300, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_STEP, 32'd2400, MODE_ROTATE, -8'sd1);
    queue_beat(CMD_TICK, 32'd2900, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'd3200, MODE_ROTATE, 8'sd0);
    // mode three only initialises
    queue_beat(CMD_START, 32'd3250, MODE_HALT, 8'sd0);
    queue_beat(CMD_TICK, 32'd3300, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'd9000, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_STEP, 32'd9100, MODE_ROTATE, 8'sd3);
    // endurance across the time wrap; stop keeps the test running
    queue_beat(CMD_START, 32'd9200, MODE_ENDURANCE, 8'sd0);
    queue_beat(CMD_TICK, 32'hFFFF_FF00, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'hFFFF_FF64, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'h0000_0100, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_STOP, 32'h0000_0150, MODE_ROTATE, 8'sd0);
    queue_beat(CMD_TICK, 32'h0000_0200, MODE_ROTATE, 8'sd0);
    sim_ms = 32'h0000_0200;
    wait_drained();

    for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
      if (chunk == 2) begin
        send_idle_pct = 54;
        recv_idle_pct = 32;
      end else if (chunk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (chunk > 0) apply_setting(chunk);
      queued = 0;
      while (queued < CHUNK_BEATS) queued = queued + queue_session(clock_span());
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
